// ===== rtl/lsq_pkg.sv =====
// ----------------------------------------------------------------------------
// lsq_pkg: shared types, constants and solve program
// Widths, controller states, datapath command and status bundles, and the
// microprogram that sequences the normal-equation solve.
// ----------------------------------------------------------------------------
package lsq_pkg;

  localparam int MaxPoints = 1024;
  localparam int CntW      = 11;
  localparam int XW        = 12;
  localparam int SxW       = 22;
  localparam int Sx2W      = 34;
  localparam int Sx3W      = 46;
  localparam int Sx4W      = 58;
  localparam int CoefW     = 32;
  localparam int W         = 192;
  localparam int BW        = 64;
  localparam int DivCntW   = 8;
  localparam int StepW     = 6;
  localparam logic [StepW-1:0] EndStep = 6'd60;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PT1, ST_PT2, ST_EXEC, ST_MWAIT, ST_DWAIT
  } state_t;

  typedef enum logic [3:0] {
    OP_CLR, OP_MAC, OP_MSB, OP_STC, OP_STD, OP_CHK, OP_STN, OP_DIV, OP_END
  } op_t;

  typedef enum logic [3:0] {
    S_N, S_SX, S_SX2, S_SX3, S_SX4, S_SY, S_SXY, S_SX2Y, S_COF
  } src_t;

  typedef struct packed {
    op_t        op;
    src_t       a_src;
    src_t       b_src;
    logic [3:0] idx;
  } instr_t;

  typedef struct packed {
    logic       pt_load;
    logic       pt_mul;
    logic       pt_acc;
    logic       clr_sums;
    logic       acc_clr;
    logic       mac_start;
    logic       mac_sub;
    src_t       a_src;
    src_t       b_src;
    logic [3:0] idx;
    logic       st_cof;
    logic       st_det;
    logic       st_num;
    logic       div_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic div_busy;
    logic det_nonpos;
  } sts_t;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    inc3 = (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  // normal matrix is Hankel: entry depends on row + column
  function automatic src_t msrc(input logic [1:0] r, input logic [1:0] c);
    logic [2:0] s;
    s = {1'b0, r} + {1'b0, c};
    case (s)
      3'd0:    msrc = S_SX4;
      3'd1:    msrc = S_SX3;
      3'd2:    msrc = S_SX2;
      3'd3:    msrc = S_SX;
      default: msrc = S_N;
    endcase
  endfunction

  function automatic src_t rsrc(input logic [1:0] j);
    case (j)
      2'd0:    rsrc = S_SX2Y;
      2'd1:    rsrc = S_SXY;
      default: rsrc = S_SY;
    endcase
  endfunction

  function automatic instr_t prog(input logic [StepW-1:0] step);
    logic [3:0] k;
    logic [3:0] jj;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] i1;
    logic [1:0] i2;
    logic [1:0] j1;
    logic [1:0] j2;
    logic [5:0] n;
    logic [5:0] five_i;
    logic [2:0] ph;
    logic [3:0] t;
    prog = '{op: OP_END, a_src: S_N, b_src: S_N, idx: 4'd0};
    if (step < 6'd36) begin
      k  = step[5:2];
      i  = (k >= 4'd6) ? 2'd2 : ((k >= 4'd3) ? 2'd1 : 2'd0);
      jj = k - {1'b0, i, 1'b0} - {2'b0, i};
      j  = jj[1:0];
      i1 = inc3(i);
      i2 = inc3(i1);
      j1 = inc3(j);
      j2 = inc3(j1);
      prog.idx = k;
      case (step[1:0])
        2'd0: prog.op = OP_CLR;
        2'd1: begin
          prog.op    = OP_MAC;
          prog.a_src = msrc(i1, j1);
          prog.b_src = msrc(i2, j2);
        end
        2'd2: begin
          prog.op    = OP_MSB;
          prog.a_src = msrc(i1, j2);
          prog.b_src = msrc(i2, j1);
        end
        default: prog.op = OP_STC;
      endcase
    end else if (step == 6'd36) begin
      prog.op = OP_CLR;
    end else if (step < 6'd40) begin
      n          = step - 6'd37;
      prog.op    = OP_MAC;
      prog.a_src = S_COF;
      prog.idx   = n[3:0];
      prog.b_src = msrc(2'd0, n[1:0]);
    end else if (step == 6'd40) begin
      prog.op = OP_STD;
    end else if (step == 6'd41) begin
      prog.op = OP_CHK;
    end else if (step < 6'd57) begin
      n      = step - 6'd42;
      i      = (n >= 6'd10) ? 2'd2 : ((n >= 6'd5) ? 2'd1 : 2'd0);
      five_i = {2'b0, i, 2'b0} + {4'b0, i};
      ph     = 3'(n - five_i);
      t      = {1'b0, i, 1'b0} + {2'b0, i} + {1'b0, ph} - 4'd1;
      if (ph == 3'd0) begin
        prog.op = OP_CLR;
      end else if (ph == 3'd4) begin
        prog.op  = OP_STN;
        prog.idx = {2'b0, i};
      end else begin
        prog.op    = OP_MAC;
        prog.a_src = S_COF;
        prog.idx   = t;
        prog.b_src = rsrc(2'(ph - 3'd1));
      end
    end else if (step < 6'd60) begin
      n        = step - 6'd57;
      prog.op  = OP_DIV;
      prog.idx = n[3:0];
    end
  endfunction

endpackage

// ===== rtl/lsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsq_ctrl: sequencing controller
// Runs the point handshake, steps the solve microprogram and owns the
// result beat valid flag.
// ----------------------------------------------------------------------------
module lsq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_point,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lsq_pkg::cmd_t cmd,
  input  lsq_pkg::sts_t sts
);

  lsq_pkg::state_t              state_r, state_nxt;
  logic [lsq_pkg::StepW-1:0]    step_r, step_nxt;
  logic                         last_r, last_nxt;
  logic                         out_valid_r, out_valid_nxt;
  lsq_pkg::instr_t              instr;
  logic                         accept;
  logic                         emit;

  assign instr  = lsq_pkg::prog(step_r);
  assign accept = in_valid && (state_r == lsq_pkg::ST_IDLE);
  assign emit   = (state_r == lsq_pkg::ST_EXEC) && (instr.op == lsq_pkg::OP_END) &&
                  (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsq_pkg::ST_IDLE;
      step_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    unique case (state_r)
      lsq_pkg::ST_IDLE: begin
        if (accept) begin
          last_nxt  = in_last_point;
          state_nxt = lsq_pkg::ST_PT1;
        end
      end
      lsq_pkg::ST_PT1: state_nxt = lsq_pkg::ST_PT2;
      lsq_pkg::ST_PT2: begin
        if (last_r) begin
          step_nxt  = '0;
          state_nxt = lsq_pkg::ST_EXEC;
        end else begin
          state_nxt = lsq_pkg::ST_IDLE;
        end
      end
      lsq_pkg::ST_EXEC: begin
        case (instr.op)
          lsq_pkg::OP_MAC, lsq_pkg::OP_MSB: state_nxt = lsq_pkg::ST_MWAIT;
          lsq_pkg::OP_DIV: state_nxt = lsq_pkg::ST_DWAIT;
          lsq_pkg::OP_CHK: step_nxt = sts.det_nonpos ? lsq_pkg::EndStep : step_r + 6'd1;
          lsq_pkg::OP_END: begin
            if (emit) state_nxt = lsq_pkg::ST_IDLE;
          end
          default: step_nxt = step_r + 6'd1;
        endcase
      end
      lsq_pkg::ST_MWAIT: begin
        if (!sts.mac_busy) begin
          step_nxt  = step_r + 6'd1;
          state_nxt = lsq_pkg::ST_EXEC;
        end
      end
      lsq_pkg::ST_DWAIT: begin
        if (!sts.div_busy) begin
          step_nxt  = step_r + 6'd1;
          state_nxt = lsq_pkg::ST_EXEC;
        end
      end
      default: state_nxt = lsq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.a_src   = instr.a_src;
    cmd.b_src   = instr.b_src;
    cmd.idx     = instr.idx;
    cmd.pt_load = accept;
    cmd.pt_mul  = (state_r == lsq_pkg::ST_PT1);
    cmd.pt_acc  = (state_r == lsq_pkg::ST_PT2);
    if (state_r == lsq_pkg::ST_EXEC) begin
      case (instr.op)
        lsq_pkg::OP_CLR: cmd.acc_clr = 1'b1;
        lsq_pkg::OP_MAC: cmd.mac_start = 1'b1;
        lsq_pkg::OP_MSB: begin
          cmd.mac_start = 1'b1;
          cmd.mac_sub   = 1'b1;
        end
        lsq_pkg::OP_STC: cmd.st_cof = 1'b1;
        lsq_pkg::OP_STD: cmd.st_det = 1'b1;
        lsq_pkg::OP_STN: cmd.st_num = 1'b1;
        lsq_pkg::OP_DIV: cmd.div_start = 1'b1;
        lsq_pkg::OP_END: begin
          cmd.out_load = emit;
          cmd.clr_sums = emit;
        end
        default: cmd.acc_clr = 1'b0;
      endcase
    end
  end

  assign in_ready  = (state_r == lsq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/lsq_dp.sv =====
// ----------------------------------------------------------------------------
// lsq_dp: accumulation and solve datapath
// Moment sums, shift-add multiply-accumulate, cofactor and numerator
// registers, restoring divider with rounding and saturation, result regs.
// ----------------------------------------------------------------------------
module lsq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [lsq_pkg::XW-1:0]     in_point_x,
  input  logic signed [lsq_pkg::XW-1:0]     in_point_y,
  input  lsq_pkg::cmd_t                     cmd,
  output lsq_pkg::sts_t                     sts,
  output logic signed [lsq_pkg::CoefW-1:0]  out_coef_a,
  output logic signed [lsq_pkg::CoefW-1:0]  out_coef_b,
  output logic signed [lsq_pkg::CoefW-1:0]  out_coef_c,
  output logic                              out_singular
);

  localparam int W  = lsq_pkg::W;
  localparam int BW = lsq_pkg::BW;
  localparam int CW = lsq_pkg::CoefW;

  logic signed [lsq_pkg::XW-1:0]     x_r, y_r;
  logic signed [2*lsq_pkg::XW-1:0]   x2_r, xy_r;
  logic signed [2*lsq_pkg::XW-1:0]   x2_w, xy_w;
  logic signed [3*lsq_pkg::XW-1:0]   x3_w, x2y_w;
  logic signed [4*lsq_pkg::XW-1:0]   x4_w;

  logic [lsq_pkg::CntW-1:0]          cnt_r;
  logic signed [lsq_pkg::SxW-1:0]    sx_r, sy_r;
  logic signed [lsq_pkg::Sx2W-1:0]   sx2_r, sxy_r;
  logic signed [lsq_pkg::Sx3W-1:0]   sx3_r, sx2y_r;
  logic signed [lsq_pkg::Sx4W-1:0]   sx4_r;

  logic signed [W-1:0]  a_val;
  logic signed [BW-1:0] b_val;
  logic signed [W-1:0]  cof_r [9];
  logic signed [W-1:0]  num_r [3];
  logic signed [W-1:0]  det_r;
  logic signed [CW-1:0] coef_r [3];

  logic                 mac_busy_r, mac_neg_r;
  logic signed [W-1:0]  ma_r, acc_r;
  logic [BW-1:0]        mb_r;

  logic                 dv_prep_r, dv_run_r, dv_fin_r;
  logic [W-1:0]         dv_n_r, dv_d_r, dv_rem_r;
  logic [CW-1:0]        dv_q_r;
  logic                 dv_big_r, dv_neg_r;
  logic [1:0]           dv_idx_r;
  logic [lsq_pkg::DivCntW-1:0] dv_cnt_r;
  logic signed [W-1:0]  dv_sel;
  logic [W-1:0]         dv_shift;
  logic [W:0]           rem_w, rem_sub;
  logic                 rem_ge;
  logic [CW-1:0]        lim, mag;
  logic                 det_nonpos;

  assign x2_w  = (2*lsq_pkg::XW)'(x_r) * (2*lsq_pkg::XW)'(x_r);
  assign xy_w  = (2*lsq_pkg::XW)'(x_r) * (2*lsq_pkg::XW)'(y_r);
  assign x3_w  = (3*lsq_pkg::XW)'(x2_r) * (3*lsq_pkg::XW)'(x_r);
  assign x2y_w = (3*lsq_pkg::XW)'(x2_r) * (3*lsq_pkg::XW)'(y_r);
  assign x4_w  = (4*lsq_pkg::XW)'(x2_r) * (4*lsq_pkg::XW)'(x2_r);

  always_ff @(posedge clk) begin
    if (cmd.pt_load) begin
      x_r <= in_point_x;
      y_r <= in_point_y;
    end
    if (cmd.pt_mul) begin
      x2_r <= x2_w;
      xy_r <= xy_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_sums) begin
      cnt_r  <= '0;
      sx_r   <= '0;
      sx2_r  <= '0;
      sx3_r  <= '0;
      sx4_r  <= '0;
      sy_r   <= '0;
      sxy_r  <= '0;
      sx2y_r <= '0;
    end else if (cmd.pt_acc && (cnt_r < lsq_pkg::CntW'(lsq_pkg::MaxPoints))) begin
      cnt_r  <= cnt_r + 1'b1;
      sx_r   <= sx_r + lsq_pkg::SxW'(x_r);
      sy_r   <= sy_r + lsq_pkg::SxW'(y_r);
      sx2_r  <= sx2_r + lsq_pkg::Sx2W'(x2_r);
      sxy_r  <= sxy_r + lsq_pkg::Sx2W'(xy_r);
      sx3_r  <= sx3_r + lsq_pkg::Sx3W'(x3_w);
      sx2y_r <= sx2y_r + lsq_pkg::Sx3W'(x2y_w);
      sx4_r  <= sx4_r + lsq_pkg::Sx4W'(x4_w);
    end
  end

  always_comb begin
    case (cmd.a_src)
      lsq_pkg::S_N:    a_val = W'(cnt_r);
      lsq_pkg::S_SX:   a_val = W'(sx_r);
      lsq_pkg::S_SX2:  a_val = W'(sx2_r);
      lsq_pkg::S_SX3:  a_val = W'(sx3_r);
      lsq_pkg::S_SX4:  a_val = W'(sx4_r);
      lsq_pkg::S_SY:   a_val = W'(sy_r);
      lsq_pkg::S_SXY:  a_val = W'(sxy_r);
      lsq_pkg::S_SX2Y: a_val = W'(sx2y_r);
      lsq_pkg::S_COF:  a_val = cof_r[cmd.idx];
      default:         a_val = '0;
    endcase
  end

  always_comb begin
    case (cmd.b_src)
      lsq_pkg::S_N:    b_val = BW'(cnt_r);
      lsq_pkg::S_SX:   b_val = BW'(sx_r);
      lsq_pkg::S_SX2:  b_val = BW'(sx2_r);
      lsq_pkg::S_SX3:  b_val = BW'(sx3_r);
      lsq_pkg::S_SX4:  b_val = BW'(sx4_r);
      lsq_pkg::S_SY:   b_val = BW'(sy_r);
      lsq_pkg::S_SXY:  b_val = BW'(sxy_r);
      lsq_pkg::S_SX2Y: b_val = BW'(sx2y_r);
      default:         b_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_busy_r <= 1'b0;
    end else if (cmd.mac_start) begin
      mac_busy_r <= 1'b1;
    end else if (mac_busy_r && (mb_r == '0)) begin
      mac_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.mac_start) begin
      ma_r      <= a_val;
      mb_r      <= b_val[BW-1] ? BW'(-b_val) : BW'(b_val);
      mac_neg_r <= b_val[BW-1] ^ cmd.mac_sub;
    end else if (mac_busy_r && (mb_r != '0)) begin
      if (mb_r[0]) acc_r <= mac_neg_r ? acc_r - ma_r : acc_r + ma_r;
      ma_r <= ma_r <<< 1;
      mb_r <= mb_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.st_cof) cof_r[cmd.idx] <= acc_r;
    if (cmd.st_num) num_r[cmd.idx[1:0]] <= acc_r;
    if (cmd.st_det) det_r <= acc_r;
  end

  assign det_nonpos = det_r[W-1] || (det_r == '0);
  assign dv_sel     = num_r[cmd.idx[1:0]];

  always_comb begin
    unique case (dv_idx_r)
      2'd0:    dv_shift = dv_n_r << 21;
      2'd1:    dv_shift = dv_n_r << 17;
      default: dv_shift = dv_n_r << 13;
    endcase
  end

  assign rem_w   = {dv_rem_r, dv_n_r[W-1]};
  assign rem_ge  = rem_w >= {1'b0, dv_d_r};
  assign rem_sub = rem_w - {1'b0, dv_d_r};
  assign lim     = dv_neg_r ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  assign mag     = (dv_big_r || (dv_q_r > lim)) ? lim : dv_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_prep_r <= 1'b0;
      dv_run_r  <= 1'b0;
      dv_fin_r  <= 1'b0;
    end else begin
      dv_prep_r <= cmd.div_start;
      if (dv_prep_r) dv_run_r <= 1'b1;
      else if (dv_run_r && (dv_cnt_r == lsq_pkg::DivCntW'(W - 1))) dv_run_r <= 1'b0;
      dv_fin_r <= dv_run_r && (dv_cnt_r == lsq_pkg::DivCntW'(W - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_neg_r <= dv_sel[W-1];
      dv_n_r   <= dv_sel[W-1] ? W'(-dv_sel) : W'(dv_sel);
      dv_idx_r <= cmd.idx[1:0];
      dv_d_r   <= W'(det_r) << 1;
      dv_rem_r <= '0;
      dv_q_r   <= '0;
      dv_big_r <= 1'b0;
      dv_cnt_r <= '0;
    end else if (dv_prep_r) begin
      dv_n_r <= dv_shift + W'(det_r);
    end else if (dv_run_r) begin
      dv_rem_r <= rem_ge ? rem_sub[W-1:0] : rem_w[W-1:0];
      dv_q_r   <= {dv_q_r[CW-2:0], rem_ge};
      dv_big_r <= dv_big_r | dv_q_r[CW-1];
      dv_n_r   <= dv_n_r << 1;
      dv_cnt_r <= dv_cnt_r + 1'b1;
    end else if (dv_fin_r) begin
      coef_r[dv_idx_r] <= dv_neg_r ? CW'(-mag) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_singular <= det_nonpos;
      out_coef_a   <= det_nonpos ? '0 : coef_r[0];
      out_coef_b   <= det_nonpos ? '0 : coef_r[1];
      out_coef_c   <= det_nonpos ? '0 : coef_r[2];
    end
  end

  assign sts.mac_busy   = mac_busy_r;
  assign sts.div_busy   = dv_prep_r | dv_run_r | dv_fin_r;
  assign sts.det_nonpos = det_nonpos;

endmodule

// ===== rtl/least_squares_parabola_fit_unit.sv =====
// ----------------------------------------------------------------------------
// least_squares_parabola_fit_unit: streaming quadratic least-squares fit
// Each point passes through accept, square and accumulate states; no new
// point is taken until it is done. Solve after the last point: 30 shift-add
// multiplies plus 3 restoring divides; when the determinant is not positive
// the numerator multiplies and the divides are skipped. One fit per set.
// Reset (rst_n low, synchronous) clears all moment sums and control state.
// ----------------------------------------------------------------------------
module least_squares_parabola_fit_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [lsq_pkg::XW-1:0]     in_point_x,
  input  logic signed [lsq_pkg::XW-1:0]     in_point_y,
  input  logic                              in_last_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lsq_pkg::CoefW-1:0]  out_coef_a,
  output logic signed [lsq_pkg::CoefW-1:0]  out_coef_b,
  output logic signed [lsq_pkg::CoefW-1:0]  out_coef_c,
  output logic                              out_singular
);

  lsq_pkg::cmd_t cmd;
  lsq_pkg::sts_t sts;

  lsq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .sts           (sts)
  );

  lsq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .cmd          (cmd),
    .sts          (sts),
    .out_coef_a   (out_coef_a),
    .out_coef_b   (out_coef_b),
    .out_coef_c   (out_coef_c),
    .out_singular (out_singular)
  );

  a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!sts.mac_busy && !sts.div_busy))
    else $error("point accepted while solve units busy");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_point) |=> !in_ready)
    else $error("input open right after last point");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |->
      (out_coef_a == '0 && out_coef_b == '0 && out_coef_c == '0))
    else $error("singular beat with nonzero coefficients");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for least_squares_parabola_fit_unit
// Streams point sets through the valid/ready input and predicts each fit from
// an exact wide-integer solve of the normal equations. It then checks every
// output beat field by field against the oldest predicted fit. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [lsq_pkg::CoefW-1:0] a;
    logic signed [lsq_pkg::CoefW-1:0] b;
    logic signed [lsq_pkg::CoefW-1:0] c;
    logic                             singular;
  } fit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [lsq_pkg::XW-1:0] in_point_x = '0;
  logic signed [lsq_pkg::XW-1:0] in_point_y = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [lsq_pkg::CoefW-1:0] out_coef_a;
  logic signed [lsq_pkg::CoefW-1:0] out_coef_b;
  logic signed [lsq_pkg::CoefW-1:0] out_coef_c;
  logic out_singular;

  logic calm = 1'b0;
  int unsigned mismatch_count = 0;
  fit_t fit_q[$];

  longint n_pts, s_x, s_x2, s_x3, s_x4, s_y, s_xy, s_x2y;

  always #1 clk = ~clk;

  least_squares_parabola_fit_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_coef_a(out_coef_a), .out_coef_b(out_coef_b), .out_coef_c(out_coef_c),
    .out_singular(out_singular)
  );

  function automatic logic [lsq_pkg::CoefW-1:0] rounded_coef(wide_t num, wide_t det,
                                                             int shift);
    logic neg;
    wide_t mag;
    wide_t q;
    wide_t limit;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = (mag <<< (shift + 1)) + det;
    q = mag / (det <<< 1);
    limit = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
    if (q > limit) q = limit;
    if (neg) q = -q;
    return q[lsq_pkg::CoefW-1:0];
  endfunction

  function automatic fit_t solve_fit();
    wide_t m[3][3];
    wide_t rhs[3];
    wide_t cof[3][3];
    wide_t det;
    wide_t num[3];
    fit_t f;
    m[0][0] = s_x4; m[0][1] = s_x3; m[0][2] = s_x2;
    m[1][0] = s_x3; m[1][1] = s_x2; m[1][2] = s_x;
    m[2][0] = s_x2; m[2][1] = s_x;  m[2][2] = n_pts;
    rhs[0] = s_x2y; rhs[1] = s_xy; rhs[2] = s_y;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                  - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
    det = 0;
    for (int j = 0; j < 3; j++) det += m[0][j] * cof[0][j];
    f = '{a: '0, b: '0, c: '0, singular: 1'b1};
    if (det > 0) begin
      for (int i = 0; i < 3; i++) begin
        num[i] = 0;
        for (int j = 0; j < 3; j++) num[i] += cof[i][j] * rhs[j];
      end
      f.a = rounded_coef(num[0], det, 20);
      f.b = rounded_coef(num[1], det, 16);
      f.c = rounded_coef(num[2], det, 12);
      f.singular = 1'b0;
    end
    return f;
  endfunction

  function automatic void clear_moments();
    n_pts = 0; s_x = 0; s_x2 = 0; s_x3 = 0; s_x4 = 0; s_y = 0; s_xy = 0; s_x2y = 0;
  endfunction

  function automatic void add_point(logic signed [lsq_pkg::XW-1:0] px,
                                    logic signed [lsq_pkg::XW-1:0] py,
                                    logic last);
    longint x;
    longint y;
    x = px;
    y = py;
    if (n_pts < lsq_pkg::MaxPoints) begin
      n_pts++;
      s_x += x; s_x2 += x*x; s_x3 += x*x*x; s_x4 += x*x*x*x;
      s_y += y; s_xy += x*y; s_x2y += x*x*y;
    end
    if (last) begin
      fit_q.push_back(solve_fit());
      clear_moments();
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) add_point(in_point_x, in_point_y, in_last_point);
  end

  always @(posedge clk) begin
    fit_t e;
    if (rst_n && out_valid && out_ready) begin
      if (fit_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected fit beat a=%0d", out_coef_a);
      end else begin
        e = fit_q.pop_front();
        if (out_coef_a !== e.a || out_coef_b !== e.b || out_coef_c !== e.c ||
            out_singular !== e.singular) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("fit mismatch: exp a=%0d b=%0d c=%0d s=%0b got a=%0d b=%0d c=%0d s=%0b",
                     e.a, e.b, e.c, e.singular,
                     out_coef_a, out_coef_b, out_coef_c, out_singular);
        end
      end
    end
  end

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 15);

  task automatic send_point(logic signed [lsq_pkg::XW-1:0] x,
                            logic signed [lsq_pkg::XW-1:0] y, logic last);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid      <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_set(int count, int xlo, int xhi);
    for (int k = 0; k < count; k++)
      send_point(lsq_pkg::XW'($urandom_range(xhi - xlo) + xlo),
                 lsq_pkg::XW'($urandom), k == count - 1);
  endtask

  task automatic test_degenerate_sets();
    send_point(12'sd5, 12'sd7, 1'b1);
    send_point(12'sd16, 12'sd3, 1'b0);
    send_point(-12'sd16, 12'sd9, 1'b1);
    send_point(12'sd4, 12'sd1, 1'b0);
    send_point(12'sd4, -12'sd2, 1'b0);
    send_point(12'sd4, 12'sd3, 1'b1);
  endtask

  task automatic test_extremes();
    send_point(-12'sd2048, -12'sd2048, 1'b0);
    send_point(12'sd0, 12'sd2047, 1'b0);
    send_point(12'sd2047, -12'sd2048, 1'b1);
    send_point(-12'sd2048, 12'sd2047, 1'b0);
    send_point(-12'sd1, 12'sd0, 1'b0);
    send_point(12'sd2047, 12'sd2047, 1'b0);
    send_point(12'sd1, -12'sd1, 1'b1);
  endtask

  task automatic test_saturation();
    send_point(-12'sd1, 12'sd2047, 1'b0);
    send_point(12'sd0, -12'sd2048, 1'b0);
    send_point(12'sd1, 12'sd2047, 1'b1);
    send_point(-12'sd1, -12'sd2048, 1'b0);
    send_point(12'sd0, 12'sd2047, 1'b0);
    send_point(12'sd1, -12'sd2048, 1'b1);
  endtask

  task automatic test_overflow_points();
    send_set(lsq_pkg::MaxPoints + 6, -2048, 2047);
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    int span;
    sent = 0;
    while (sent < 950) begin
      calm = (sent > 300 && sent < 600);
      case ($urandom_range(9))
        0:       len = $urandom_range(2, 1);
        1:       len = $urandom_range(200, 41);
        default: len = $urandom_range(40, 3);
      endcase
      span = $urandom_range(1) ? 2047 : $urandom_range(40, 1);
      send_set(len, -span - 1, span);
      sent += len;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_degenerate_sets();
    test_extremes();
    test_saturation();
    test_overflow_points();
    test_random_sets();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fit_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lsq_pkg.sv
rtl/lsq_ctrl.sv
rtl/lsq_dp.sv
rtl/least_squares_parabola_fit_unit.sv
test/tb_top.sv
